FILE: rtl/core/cgrn_pkg.sv
// Shared types and constants for the cylinder grid ring neighbor block.
package cgrn_pkg;

  localparam int MAX_CELLS_PER_WHEEL = 256;
  localparam int MAX_WHEELS          = 64;
  localparam int MAX_LEVEL           = 8;

  localparam int IDX_W   = 14;
  localparam int LVL_W   = 4;
  localparam int CPW_W   = 9;
  localparam int WC_W    = 7;
  localparam int WHEEL_W = 6;
  localparam int POS_W   = 8;
  localparam int OFS_W   = 5;
  localparam int WSUM_W  = 8;
  localparam int PROD_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int DIV_CNT_W  = $clog2(IDX_W);

  localparam logic signed [OFS_W-1:0] OFS_ONE = OFS_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_WHEEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_COUNT     = 2'd1;

  localparam logic [CPW_W-1:0] CPW_RESET = 9'd256;
  localparam logic [WC_W-1:0]  WC_RESET  = 7'd64;

  typedef struct packed {
    logic [CPW_W-1:0] cells_per_wheel;
    logic [WC_W-1:0]  wheel_count;
  } cfg_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [POS_W-1:0]   pos;
    logic [LVL_W-1:0]   level;
    logic               bad;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PRE,
    B_WALK,
    B_FLUSH
  } back_state_t;

  typedef enum logic [1:0] {
    SEG_POS_HI,
    SEG_WHEEL_HI,
    SEG_POS_LO,
    SEG_WHEEL_LO
  } seg_t;

endpackage

FILE: rtl/core/cylinder_grid_ring_neighbors.sv
// Top level of the cylinder grid ring neighbor block.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------------
//  in       | start, busy               | in_cell_index, in_ring_level
//  out      | out_valid (strobe)        | out_neighbor_index, out_last_of_run,
//           |                           | out_bad_request
//  cfg      | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// The front end holds busy while it decodes a request, and longer while the job queue is
// full, as a one-bit-per-cycle divider splits the cell index into wheel and position.
// The ring walker fetches a job, offsets the position by the ring level, scans the ring
// and flushes; results are registered. A bad job yields one error result at the fetch.
// Reset is synchronous; it restores 256 cells per wheel and 64 wheels.
// Results are strobed for one cycle and cannot be stalled.
module cylinder_grid_ring_neighbors (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [cgrn_pkg::IDX_W-1:0]     in_cell_index,
  input  logic [cgrn_pkg::LVL_W-1:0]     in_ring_level,
  output logic                           out_valid,
  output logic [cgrn_pkg::IDX_W-1:0]     out_neighbor_index,
  output logic                           out_last_of_run,
  output logic                           out_bad_request,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cgrn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cgrn_pkg::CPW_W-1:0]     cfg_data
);

  cgrn_pkg::cfg_t cfg_r;
  cgrn_pkg::job_t push_job;
  cgrn_pkg::job_t head_job;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  logic           front_busy;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_per_wheel <= cgrn_pkg::CPW_RESET;
      cfg_r.wheel_count     <= cgrn_pkg::WC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cgrn_pkg::REG_CELLS_PER_WHEEL) begin
        cfg_r.cells_per_wheel <= cfg_data;
      end else if (cfg_index == cgrn_pkg::REG_WHEEL_COUNT) begin
        cfg_r.wheel_count <= cfg_data[cgrn_pkg::WC_W-1:0];
      end
    end
  end

  cgrn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (front_busy),
    .cell_index (in_cell_index),
    .ring_level (in_ring_level),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  cgrn_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  cgrn_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_job              (head_job),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_neighbor_index (out_neighbor_index),
    .out_last_of_run    (out_last_of_run),
    .out_bad_request    (out_bad_request)
  );

endmodule

FILE: rtl/core/cgrn_front.sv
// Front end: accepts a request, checks it and splits the cell index by division.
module cgrn_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cgrn_pkg::IDX_W-1:0]   cell_index,
  input  logic [cgrn_pkg::LVL_W-1:0]   ring_level,
  input  cgrn_pkg::cfg_t               cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output cgrn_pkg::job_t               q_job
);

  cgrn_pkg::front_state_t state_r, state_nxt;

  logic [cgrn_pkg::IDX_W-1:0]     quo_r, quo_nxt;
  logic [cgrn_pkg::CPW_W-1:0]     rem_r, rem_nxt;
  logic [cgrn_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [cgrn_pkg::LVL_W-1:0]     lvl_r, lvl_nxt;
  logic                           bad_r, bad_nxt;

  logic [cgrn_pkg::PROD_W-1:0] grid_size;
  logic                        cfg_bad;
  logic                        req_bad;
  logic [cgrn_pkg::CPW_W:0]    trial;
  logic                        trial_ge;

  assign grid_size = cgrn_pkg::PROD_W'(cfg.cells_per_wheel) *
                     cgrn_pkg::PROD_W'(cfg.wheel_count);
  assign cfg_bad = (cfg.cells_per_wheel == '0) ||
                   (cfg.cells_per_wheel > cgrn_pkg::CPW_W'(cgrn_pkg::MAX_CELLS_PER_WHEEL)) ||
                   (cfg.wheel_count == '0) ||
                   (cfg.wheel_count > cgrn_pkg::WC_W'(cgrn_pkg::MAX_WHEELS));
  assign req_bad = cfg_bad ||
                   (ring_level > cgrn_pkg::LVL_W'(cgrn_pkg::MAX_LEVEL)) ||
                   (cgrn_pkg::PROD_W'(cell_index) >= grid_size);

  assign trial    = {rem_r, quo_r[cgrn_pkg::IDX_W-1]};
  assign trial_ge = trial >= {1'b0, cfg.cells_per_wheel};

  assign busy = (state_r != cgrn_pkg::F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cgrn_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    lvl_r <= lvl_nxt;
    bad_r <= bad_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    bad_nxt   = bad_r;
    q_push    = 1'b0;
    q_job.wheel = quo_r[cgrn_pkg::WHEEL_W-1:0];
    q_job.pos   = rem_r[cgrn_pkg::POS_W-1:0];
    q_job.level = lvl_r;
    q_job.bad   = bad_r;
    unique case (state_r)
      cgrn_pkg::F_IDLE: begin
        if (start) begin
          quo_nxt   = cell_index;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          lvl_nxt   = ring_level;
          bad_nxt   = req_bad;
          state_nxt = cgrn_pkg::F_DIV;
        end
      end
      cgrn_pkg::F_DIV: begin
        if (trial_ge) begin
          rem_nxt = cgrn_pkg::CPW_W'(trial - {1'b0, cfg.cells_per_wheel});
        end else begin
          rem_nxt = trial[cgrn_pkg::CPW_W-1:0];
        end
        quo_nxt = {quo_r[cgrn_pkg::IDX_W-2:0], trial_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == cgrn_pkg::DIV_CNT_W'(cgrn_pkg::IDX_W - 1)) begin
          state_nxt = cgrn_pkg::F_PUSH;
        end
      end
      cgrn_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = cgrn_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = cgrn_pkg::F_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/cgrn_fifo.sv
// Short queue of decoded jobs between the front end and the ring walker.
module cgrn_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cgrn_pkg::job_t push_job,
  input  logic           pop,
  output cgrn_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);

  cgrn_pkg::job_t mem_r [cgrn_pkg::FIFO_DEPTH];

  logic [cgrn_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [cgrn_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [cgrn_pkg::FIFO_PTR_W:0]   count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (cgrn_pkg::FIFO_PTR_W + 1)'(cgrn_pkg::FIFO_DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/cgrn_back.sv
// Back end: walks the square ring of one job and emits the neighbor indices.
module cgrn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cgrn_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  cgrn_pkg::job_t              q_job,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [cgrn_pkg::IDX_W-1:0]  out_neighbor_index,
  output logic                        out_last_of_run,
  output logic                        out_bad_request
);

  cgrn_pkg::back_state_t state_r, state_nxt;
  cgrn_pkg::seg_t        seg_r, seg_nxt;

  logic [cgrn_pkg::WHEEL_W-1:0]     wheel_r, wheel_nxt;
  logic [cgrn_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [cgrn_pkg::LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [cgrn_pkg::LVL_W-1:0]       cnt_r, cnt_nxt;
  logic signed [cgrn_pkg::OFS_W-1:0] ofs_r, ofs_nxt;
  logic                             pend_vld_r, pend_vld_nxt;
  logic [cgrn_pkg::IDX_W-1:0]       pend_idx_r, pend_idx_nxt;

  logic                             out_valid_r;
  logic [cgrn_pkg::IDX_W-1:0]       out_idx_r;
  logic                             out_last_r;
  logic                             out_bad_r;

  logic                             emit_vld;
  logic [cgrn_pkg::IDX_W-1:0]       emit_idx;
  logic                             emit_last;
  logic                             emit_bad;

  logic signed [cgrn_pkg::OFS_W-1:0]  lvl_s;
  logic signed [cgrn_pkg::OFS_W-1:0]  dw;
  logic signed [cgrn_pkg::WSUM_W-1:0] cand_wheel;
  logic                               cand_ok;
  logic [cgrn_pkg::PROD_W-1:0]        cand_full;
  logic [cgrn_pkg::POS_W-1:0]         pos_inc;
  logic [cgrn_pkg::POS_W-1:0]         pos_dec;
  logic                               walk_end;

  assign lvl_s = cgrn_pkg::OFS_W'(lvl_r);

  always_comb begin
    unique case (seg_r)
      cgrn_pkg::SEG_POS_HI:   dw = ofs_r;
      cgrn_pkg::SEG_WHEEL_HI: dw = lvl_s;
      cgrn_pkg::SEG_POS_LO:   dw = ofs_r;
      cgrn_pkg::SEG_WHEEL_LO: dw = -lvl_s;
      default:                dw = ofs_r;
    endcase
  end

  assign cand_wheel = $signed(cgrn_pkg::WSUM_W'(wheel_r)) +
                      $signed({{(cgrn_pkg::WSUM_W - cgrn_pkg::OFS_W){dw[cgrn_pkg::OFS_W-1]}}, dw});
  assign cand_ok    = !cand_wheel[cgrn_pkg::WSUM_W-1] &&
                      (cand_wheel[cgrn_pkg::WC_W-1:0] < cfg.wheel_count);
  assign cand_full  = cgrn_pkg::PROD_W'(cand_wheel[cgrn_pkg::WC_W-1:0]) *
                      cgrn_pkg::PROD_W'(cfg.cells_per_wheel) +
                      cgrn_pkg::PROD_W'(pos_r);

  assign pos_inc = ({1'b0, pos_r} + 1'b1 == cfg.cells_per_wheel) ?
                   '0 : pos_r + 1'b1;
  assign pos_dec = (pos_r == '0) ?
                   cgrn_pkg::POS_W'(cfg.cells_per_wheel - 1'b1) : pos_r - 1'b1;

  assign walk_end = ((seg_r == cgrn_pkg::SEG_POS_HI) && (ofs_r == lvl_s) && (lvl_r == '0)) ||
                    ((seg_r == cgrn_pkg::SEG_WHEEL_LO) &&
                     (ofs_r == lvl_s - cgrn_pkg::OFS_ONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgrn_pkg::B_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= emit_vld;
    end
    seg_r      <= seg_nxt;
    wheel_r    <= wheel_nxt;
    pos_r      <= pos_nxt;
    lvl_r      <= lvl_nxt;
    cnt_r      <= cnt_nxt;
    ofs_r      <= ofs_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (emit_vld) begin
      out_idx_r  <= emit_idx;
      out_last_r <= emit_last;
      out_bad_r  <= emit_bad;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    seg_nxt      = seg_r;
    wheel_nxt    = wheel_r;
    pos_nxt      = pos_r;
    lvl_nxt      = lvl_r;
    cnt_nxt      = cnt_r;
    ofs_nxt      = ofs_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    q_pop        = 1'b0;
    emit_vld     = 1'b0;
    emit_idx     = pend_idx_r;
    emit_last    = 1'b0;
    emit_bad     = 1'b0;
    unique case (state_r)
      cgrn_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_job.bad) begin
            emit_vld  = 1'b1;
            emit_idx  = '0;
            emit_last = 1'b1;
            emit_bad  = 1'b1;
          end else begin
            wheel_nxt = q_job.wheel;
            pos_nxt   = q_job.pos;
            lvl_nxt   = q_job.level;
            cnt_nxt   = q_job.level;
            ofs_nxt   = -cgrn_pkg::OFS_W'(q_job.level);
            seg_nxt   = cgrn_pkg::SEG_POS_HI;
            state_nxt = (q_job.level == '0) ? cgrn_pkg::B_WALK : cgrn_pkg::B_PRE;
          end
        end
      end
      cgrn_pkg::B_PRE: begin
        pos_nxt = pos_inc;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == cgrn_pkg::LVL_W'(1)) begin
          state_nxt = cgrn_pkg::B_WALK;
        end
      end
      cgrn_pkg::B_WALK: begin
        if (cand_ok) begin
          emit_vld     = pend_vld_r;
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = cand_full[cgrn_pkg::IDX_W-1:0];
        end
        if (walk_end) begin
          state_nxt = cgrn_pkg::B_FLUSH;
        end else begin
          unique case (seg_r)
            cgrn_pkg::SEG_POS_HI: begin
              if (ofs_r == lvl_s) begin
                seg_nxt = cgrn_pkg::SEG_WHEEL_HI;
                ofs_nxt = lvl_s - cgrn_pkg::OFS_ONE;
                pos_nxt = pos_dec;
              end else begin
                ofs_nxt = ofs_r + cgrn_pkg::OFS_ONE;
              end
            end
            cgrn_pkg::SEG_WHEEL_HI: begin
              if (ofs_r == -lvl_s) begin
                seg_nxt = cgrn_pkg::SEG_POS_LO;
                ofs_nxt = lvl_s - cgrn_pkg::OFS_ONE;
              end else begin
                ofs_nxt = ofs_r - cgrn_pkg::OFS_ONE;
                pos_nxt = pos_dec;
              end
            end
            cgrn_pkg::SEG_POS_LO: begin
              if (ofs_r == -lvl_s) begin
                seg_nxt = cgrn_pkg::SEG_WHEEL_LO;
                ofs_nxt = cgrn_pkg::OFS_ONE - lvl_s;
                pos_nxt = pos_inc;
              end else begin
                ofs_nxt = ofs_r - cgrn_pkg::OFS_ONE;
              end
            end
            cgrn_pkg::SEG_WHEEL_LO: begin
              ofs_nxt = ofs_r + cgrn_pkg::OFS_ONE;
              pos_nxt = pos_inc;
            end
            default: begin
              seg_nxt = cgrn_pkg::SEG_POS_HI;
            end
          endcase
        end
      end
      cgrn_pkg::B_FLUSH: begin
        emit_vld     = 1'b1;
        emit_last    = 1'b1;
        pend_vld_nxt = 1'b0;
        state_nxt    = cgrn_pkg::B_IDLE;
      end
      default: begin
        state_nxt = cgrn_pkg::B_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_index = out_idx_r;
  assign out_last_of_run    = out_last_r;
  assign out_bad_request    = out_bad_r;

endmodule

FILE: rtl/core/cgrn_checker.sv
// Port-level checker for the ring neighbor block and its bind statement.
module cgrn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [cgrn_pkg::IDX_W-1:0]     out_neighbor_index,
  input logic                           out_last_of_run,
  input logic                           out_bad_request
);

  // An error transaction always ends its run and carries a zero index.
  a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_last_of_run && (out_neighbor_index == '0))
    else $error("bad request result not final or index not zero");

  // An accepted request keeps the input side busy while it is decoded.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy ##1 busy)
    else $error("busy dropped right after an accepted request");

  // Reset leaves both channels quiet.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

  // No result appears right after reset, before any request could be decoded.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid ##1 !out_valid)
    else $error("result without a request");

endmodule

bind cylinder_grid_ring_neighbors cgrn_checker u_cgrn_checker (.*);
